// ===== src/wmps_pkg.sv =====
// Shared constants, register codes and inter-stage types of the weighted motif presence scorer.
// No dependencies.
package wmps_pkg;

    localparam int MAX_MOTIFS_DEF       = 4;
    localparam int MAX_MOTIF_LENGTH_DEF = 8;
    localparam int SYMBOL_BITS_DEF      = 6;

    localparam int ENTRY_SLOTS    = 4;
    localparam int CODE_STRIDE    = 6;
    localparam int CODE_BITS      = 48;
    localparam int WEIGHT_LSB     = 48;
    localparam int WEIGHT_BITS    = 16;
    localparam int SCORE_BITS     = 18;
    localparam int COUNT_BITS     = 3;
    localparam int LEN_BITS       = 4;
    localparam int CFG_DATA_BITS  = 64;
    localparam int CFG_INDEX_BITS = 3;
    localparam int IN_TDATA_BITS  = 8;
    localparam int OUT_TDATA_BITS = 32;
    localparam int OUT_USED_BITS  = SCORE_BITS + COUNT_BITS + ENTRY_SLOTS + 2;

    localparam logic [LEN_BITS-1:0]   LEN_RESET   = 4'd5;
    localparam logic [COUNT_BITS-1:0] COUNT_RESET = 3'd4;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_MOTIF_LENGTH = 3'd0,
        REG_MOTIF_COUNT  = 3'd1,
        REG_ENTRY_0      = 3'd2,
        REG_ENTRY_1      = 3'd3,
        REG_ENTRY_2      = 3'd4,
        REG_ENTRY_3      = 3'd5,
        REG_THRESHOLD    = 3'd6
    } cfg_reg_t;

    // found mask of a finished sequence, matcher to scorer
    typedef struct packed {
        logic                   valid;
        logic [ENTRY_SLOTS-1:0] mask;
    } match_word_t;

endpackage

// ===== src/weighted_motif_presence_scorer.sv =====
// Top level of the weighted motif presence scorer: configuration registers,
// matcher and scorer. Depends on wmps_pkg, wmps_matcher and wmps_scorer.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata: symbol; s_tlast: end_of_sequence
//  m_      | out | m_tvalid/m_tready  | m_tdata: score, found_count, found_mask, ...
//  cfg_    | in  | cfg_we             | cfg_index, cfg_wdata
//
// One symbol word per cycle while s_tready is high, set by the combinational
// window compare of all motifs. The last symbol of a sequence is registered in the
// mask register, then in the result register, before the result word is valid.
// Reset clears the history, the found flags and the valid flags of both registers.
// With m_tready low the result and one finished mask are held; the input stalls only
// when both are occupied.
module weighted_motif_presence_scorer #(
    parameter int MAX_MOTIFS       = wmps_pkg::MAX_MOTIFS_DEF,
    parameter int MAX_MOTIF_LENGTH = wmps_pkg::MAX_MOTIF_LENGTH_DEF,
    parameter int SYMBOL_BITS      = wmps_pkg::SYMBOL_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [wmps_pkg::IN_TDATA_BITS-1:0]   s_tdata,   // [5:0] symbol, rest zero
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [17:0] score, [20:18] found_count, [24:21] found_mask, [25] no_motif,
    // [26] positive_class, rest zero
    output logic [wmps_pkg::OUT_TDATA_BITS-1:0]  m_tdata,
    input  logic                                 cfg_we,
    input  logic [wmps_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [wmps_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
    import wmps_pkg::*;

    logic [LEN_BITS-1:0]          win_len_reg;
    logic [COUNT_BITS-1:0]        motif_count_reg;
    logic [CFG_DATA_BITS-1:0]     entry_reg [MAX_MOTIFS];
    logic signed [SCORE_BITS-1:0] threshold_reg;

    logic                                   entry_we;
    logic [1:0]                             entry_sel;
    logic [MAX_MOTIFS-1:0][CODE_BITS-1:0]   codes;
    logic [ENTRY_SLOTS-1:0][WEIGHT_BITS-1:0] weights;
    match_word_t                            match_word;
    logic                                   match_ready;

    always_comb begin
        entry_we  = 1'b0;
        entry_sel = 2'(cfg_index - REG_ENTRY_0);
        case (cfg_reg_t'(cfg_index))
            REG_ENTRY_0, REG_ENTRY_1, REG_ENTRY_2, REG_ENTRY_3: begin
                entry_we = cfg_we;
            end
            default: begin
                entry_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_len_reg      <= LEN_RESET;
            motif_count_reg  <= COUNT_RESET;
            threshold_reg    <= '0;
            for (int k = 0; k < MAX_MOTIFS; k++) begin
                entry_reg[k] <= '0;
            end
        end else begin
            if (cfg_we && cfg_index == REG_MOTIF_LENGTH) begin
                win_len_reg <= cfg_wdata[LEN_BITS-1:0];
            end
            if (cfg_we && cfg_index == REG_MOTIF_COUNT) begin
                motif_count_reg <= cfg_wdata[COUNT_BITS-1:0];
            end
            if (cfg_we && cfg_index == REG_THRESHOLD) begin
                threshold_reg <= signed'(cfg_wdata[SCORE_BITS-1:0]);
            end
            for (int k = 0; k < MAX_MOTIFS; k++) begin
                if (entry_we && entry_sel == 2'(k)) begin
                    entry_reg[k] <= cfg_wdata;
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < MAX_MOTIFS; k++) begin
            codes[k] = entry_reg[k][CODE_BITS-1:0];
        end
        for (int k = 0; k < ENTRY_SLOTS; k++) begin
            weights[k] = '0;
            if (k < MAX_MOTIFS) begin
                weights[k] = entry_reg[k][WEIGHT_LSB +: WEIGHT_BITS];
            end
        end
    end

    wmps_matcher #(
        .MAX_MOTIFS       (MAX_MOTIFS),
        .MAX_MOTIF_LENGTH (MAX_MOTIF_LENGTH),
        .SYMBOL_BITS      (SYMBOL_BITS)
    ) u_matcher (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .symbol          (s_tdata[SYMBOL_BITS-1:0]),
        .end_of_sequence (s_tlast),
        .win_len         (win_len_reg),
        .motif_count     (motif_count_reg),
        .motif_codes     (codes),
        .dn_word         (match_word),
        .dn_ready        (match_ready)
    );

    wmps_scorer u_scorer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .up_word   (match_word),
        .up_ready  (match_ready),
        .weights   (weights),
        .threshold (threshold_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== src/wmps_matcher.sv =====
// Symbol history, window compare against all motifs, and found-flag tracking.
// Hands the found mask of each finished sequence to the scorer. Depends on wmps_pkg.
module wmps_matcher #(
    parameter int MAX_MOTIFS       = 4,
    parameter int MAX_MOTIF_LENGTH = 8,
    parameter int SYMBOL_BITS      = 6
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  logic                                            s_tvalid,
    output logic                                            s_tready,
    input  logic [SYMBOL_BITS-1:0]                          symbol,
    input  logic                                            end_of_sequence,
    input  logic [wmps_pkg::LEN_BITS-1:0]                   win_len,
    input  logic [wmps_pkg::COUNT_BITS-1:0]                 motif_count,
    input  logic [MAX_MOTIFS-1:0][wmps_pkg::CODE_BITS-1:0]  motif_codes,
    output wmps_pkg::match_word_t                           dn_word,
    input  logic                                            dn_ready
);
    import wmps_pkg::*;

    localparam int HIST_DEPTH = (MAX_MOTIF_LENGTH > 1) ? MAX_MOTIF_LENGTH - 1 : 1;
    localparam int SEEN_BITS  = $clog2(MAX_MOTIF_LENGTH + 1);

    logic [SYMBOL_BITS-1:0] hist_reg  [HIST_DEPTH];
    logic [SYMBOL_BITS-1:0] hist_next [HIST_DEPTH];
    logic [SYMBOL_BITS-1:0] window    [MAX_MOTIF_LENGTH];
    logic [SEEN_BITS-1:0]   seen_reg, seen_next;
    logic [MAX_MOTIFS-1:0]  flags_reg, flags_next;
    logic [MAX_MOTIFS-1:0]  hit;
    logic                   out_valid_reg, out_valid_next;
    logic [ENTRY_SLOTS-1:0] out_mask_reg, out_mask_next;
    logic [LEN_BITS-1:0]    len_eff;
    logic [COUNT_BITS-1:0]  cnt_eff;
    logic                   enough;
    logic                   accept;

    assign s_tready = !out_valid_reg || dn_ready;
    assign accept   = s_tvalid && s_tready;

    assign len_eff = (win_len > LEN_BITS'(MAX_MOTIF_LENGTH)) ?
                     LEN_BITS'(MAX_MOTIF_LENGTH) : win_len;
    assign cnt_eff = (motif_count > COUNT_BITS'(MAX_MOTIFS)) ?
                     COUNT_BITS'(MAX_MOTIFS) : motif_count;
    assign enough  = ({1'b0, seen_reg} + (SEEN_BITS+1)'(1)) >= (SEEN_BITS+1)'(len_eff);

    always_comb begin
        window[0] = symbol;
        for (int i = 1; i < MAX_MOTIF_LENGTH; i++) begin
            window[i] = hist_reg[i-1];
        end
    end

    // every motif length is checked in parallel, then the configured one is picked
    always_comb begin
        logic m;
        logic sel;
        for (int k = 0; k < MAX_MOTIFS; k++) begin
            sel = 1'b0;
            for (int l = 1; l <= MAX_MOTIF_LENGTH; l++) begin
                m = 1'b1;
                for (int j = 0; j < l; j++) begin
                    if (window[l-1-j] != motif_codes[k][CODE_STRIDE*j +: SYMBOL_BITS]) begin
                        m = 1'b0;
                    end
                end
                if (len_eff == LEN_BITS'(l)) begin
                    sel = m;
                end
            end
            if (COUNT_BITS'(k) >= cnt_eff) begin
                hit[k] = 1'b0;
            end else if (len_eff == '0) begin
                hit[k] = end_of_sequence;
            end else begin
                hit[k] = enough && sel;
            end
        end
    end

    always_comb begin
        hist_next      = hist_reg;
        seen_next      = seen_reg;
        flags_next     = flags_reg;
        out_mask_next  = out_mask_reg;
        out_valid_next = out_valid_reg && !dn_ready;
        if (accept) begin
            if (end_of_sequence) begin
                out_valid_next = 1'b1;
                out_mask_next  = ENTRY_SLOTS'(flags_reg | hit);
                flags_next     = '0;
                seen_next      = '0;
                for (int i = 0; i < HIST_DEPTH; i++) begin
                    hist_next[i] = '0;
                end
            end else begin
                flags_next   = flags_reg | hit;
                hist_next[0] = symbol;
                for (int i = 1; i < HIST_DEPTH; i++) begin
                    hist_next[i] = hist_reg[i-1];
                end
                if (seen_reg < SEEN_BITS'(MAX_MOTIF_LENGTH)) begin
                    seen_next = seen_reg + SEEN_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < HIST_DEPTH; i++) begin
                hist_reg[i] <= '0;
            end
            seen_reg      <= '0;
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            hist_reg      <= hist_next;
            seen_reg      <= seen_next;
            flags_reg     <= flags_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_mask_reg <= out_mask_next;
    end

    assign dn_word.valid = out_valid_reg;
    assign dn_word.mask  = out_mask_reg;

endmodule

// ===== src/wmps_scorer.sv =====
// Weight sum, motif count, flags and threshold compare, into the output register.
// Fed by wmps_matcher; depends on wmps_pkg.
module wmps_scorer (
    input  logic                                                 aclk,
    input  logic                                                 aresetn,
    input  wmps_pkg::match_word_t                                up_word,
    output logic                                                 up_ready,
    input  logic [wmps_pkg::ENTRY_SLOTS-1:0][wmps_pkg::WEIGHT_BITS-1:0] weights,
    input  logic signed [wmps_pkg::SCORE_BITS-1:0]               threshold,
    output logic                                                 m_tvalid,
    input  logic                                                 m_tready,
    output logic [wmps_pkg::OUT_TDATA_BITS-1:0]                  m_tdata
);
    import wmps_pkg::*;

    logic                         m_tvalid_reg, m_tvalid_next;
    logic signed [SCORE_BITS-1:0] score_reg, score_next;
    logic [COUNT_BITS-1:0]        count_reg, count_next;
    logic [ENTRY_SLOTS-1:0]       mask_reg;
    logic                         none_reg, pos_reg;
    logic                         load;

    assign up_ready = !m_tvalid_reg || m_tready;
    assign load     = up_word.valid && up_ready;

    always_comb begin
        score_next = '0;
        count_next = '0;
        for (int k = 0; k < ENTRY_SLOTS; k++) begin
            if (up_word.mask[k]) begin
                score_next = score_next + SCORE_BITS'(signed'(weights[k]));
                count_next = count_next + COUNT_BITS'(1);
            end
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (load) begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            score_reg <= score_next;
            count_reg <= count_next;
            mask_reg  <= up_word.mask;
            none_reg  <= (count_next == '0);
            pos_reg   <= (score_next > threshold);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(OUT_TDATA_BITS-OUT_USED_BITS)'(0), pos_reg, none_reg, mask_reg,
                       count_reg, score_reg};

endmodule
